FILE: design/bls_pkg.sv
// Shared types, constants and codes for the balanced list assignment search.
package bls_pkg;

  // Field and counter widths fixed by the interface.
  localparam int CNT_W     = 6;
  localparam int IDX_W     = 5;
  localparam int ACT_W     = 2;
  localparam int CFG_IDX_W = 2;

  // Default table sizes.
  localparam int DEF_MAX_TEACHERS = 32;
  localparam int DEF_MAX_SUBJECTS = 32;

  // Best load before any complete assignment is seen.
  localparam logic [CNT_W-1:0] NONE_YET = 6'd33;

  // Action codes.
  localparam logic [ACT_W-1:0] ACT_CAPABILITY = 2'd0;
  localparam logic [ACT_W-1:0] ACT_CONFLICT   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_SOLVE      = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TEACHER_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SUBJECT_COUNT = 2'd1;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SEARCH,
    ST_FINISH
  } bls_state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load_cap;
    logic load_conf;
    logic start;
    logic div_step;
    logic search_step;
    logic emit;
  } bls_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic div_last;
    logic search_done;
    logic out_free;
  } bls_status_t;

endpackage

FILE: design/balanced_list_assignment_search.sv
// Table and configuration words are taken one word per cycle (table words only when
// idle). Solve word: the load bound is found by repeated subtraction, candidate
// teachers are tried one per search step, and a backtrack steps back to the previous
// subject, then releases its teacher's load; at the search end the output register is
// loaded (held while the previous result word is stalled); intake reopens as the result
// word appears. Reset (synchronous, rst_n low) clears both tables, sets counts to 1.
module balanced_list_assignment_search
  import bls_pkg::*;
#(
  parameter int MAX_TEACHERS = DEF_MAX_TEACHERS,
  parameter int MAX_SUBJECTS = DEF_MAX_SUBJECTS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [ACT_W-1:0]      in_action,
  input  logic [IDX_W-1:0]      in_first_index,
  input  logic [IDX_W-1:0]      in_second_index,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CNT_W-1:0]      out_best_load,
  output logic                  out_found,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CNT_W-1:0]      cfg_data
);

  bls_cmd_t    cmd;
  bls_status_t status;

  // Configuration is always taken
  assign cfg_ready = 1'b1;

  bls_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_stall  (in_stall),
    .status    (status),
    .cmd       (cmd)
  );

  bls_dp #(
    .MAX_TEACHERS (MAX_TEACHERS),
    .MAX_SUBJECTS (MAX_SUBJECTS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_first_index  (in_first_index),
    .in_second_index (in_second_index),
    .cmd             (cmd),
    .status          (status),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_best_load   (out_best_load),
    .out_found       (out_found)
  );

endmodule

FILE: design/bls_ctrl.sv
// Controller state machine: item intake, bound division, search and result hand-off.
module bls_ctrl
  import bls_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [ACT_W-1:0]  in_action,
  output logic              in_stall,
  input  bls_status_t       status,
  output bls_cmd_t          cmd
);

  bls_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && (in_action == ACT_SOLVE)) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (status.div_last) state_nxt = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (status.search_done) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (status.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          case (in_action)
            ACT_CAPABILITY: cmd.load_cap  = 1'b1;
            ACT_CONFLICT:   cmd.load_conf = 1'b1;
            ACT_SOLVE:      cmd.start     = 1'b1;
            default:        ; // unknown action: word is dropped
          endcase
        end
      end
      ST_DIV:    cmd.div_step    = 1'b1;
      ST_SEARCH: cmd.search_step = 1'b1;
      ST_FINISH: cmd.emit        = status.out_free;
      default:   ;
    endcase
  end

endmodule

FILE: design/bls_dp.sv
// Datapath: tables, search stack, bound division and output register.
module bls_dp
  import bls_pkg::*;
#(
  parameter int MAX_TEACHERS = DEF_MAX_TEACHERS,
  parameter int MAX_SUBJECTS = DEF_MAX_SUBJECTS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CNT_W-1:0]      cfg_data,
  input  logic [IDX_W-1:0]      in_first_index,
  input  logic [IDX_W-1:0]      in_second_index,
  input  bls_cmd_t              cmd,
  output bls_status_t           status,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CNT_W-1:0]      out_best_load,
  output logic                  out_found
);

  localparam int TW = (MAX_TEACHERS > 1) ? $clog2(MAX_TEACHERS) : 1;
  localparam int SW = (MAX_SUBJECTS > 1) ? $clog2(MAX_SUBJECTS) : 1;
  localparam logic [CNT_W-1:0] MAX_T_C = CNT_W'(MAX_TEACHERS);
  localparam logic [CNT_W-1:0] MAX_S_C = CNT_W'(MAX_SUBJECTS);

  // Configuration and tables
  logic [CNT_W-1:0]        tc_r, sc_r;
  logic [MAX_TEACHERS-1:0] cap_r  [MAX_SUBJECTS];
  logic [MAX_SUBJECTS-1:0] conf_r [MAX_SUBJECTS];

  // Search state
  logic [SW-1:0]    s_r;
  logic [CNT_W-1:0] t_r;
  logic             pending_r;
  logic [CNT_W-1:0] best_r, lb_r, rem_r;
  logic [TW-1:0]    assigned_r [MAX_SUBJECTS];
  logic [CNT_W-1:0] load_r     [MAX_TEACHERS];
  logic [CNT_W-1:0] cm_r       [MAX_SUBJECTS];

  // Output register
  logic             out_valid_r;
  logic [CNT_W-1:0] out_best_load_r;
  logic             out_found_r;

  // Clamped counts in use
  logic [CNT_W-1:0] ut, us;
  always_comb begin
    if (tc_r == '0)         ut = CNT_W'(1);
    else if (tc_r > MAX_T_C) ut = MAX_T_C;
    else                     ut = tc_r;
    if (sc_r == '0)         us = CNT_W'(1);
    else if (sc_r > MAX_S_C) us = MAX_S_C;
    else                     us = sc_r;
  end

  // Index range checks for table loads
  logic cap_ok, conf_ok;
  assign cap_ok  = ({1'b0, in_first_index} < MAX_T_C) && ({1'b0, in_second_index} < MAX_S_C);
  assign conf_ok = ({1'b0, in_first_index} < MAX_S_C) && ({1'b0, in_second_index} < MAX_S_C);

  // One candidate teacher per step
  logic [TW-1:0]           t_idx, tp;
  logic [SW-1:0]           s_prev, s_next;
  logic                    t_end, cap_bit, clash, prune, ok, leaf;
  logic [CNT_W-1:0]        cur_max, nl, nm;
  logic [MAX_SUBJECTS-1:0] conf_row, hit;

  assign t_idx    = t_r[TW-1:0];
  assign s_prev   = s_r - SW'(1);
  assign s_next   = s_r + SW'(1);
  assign tp       = assigned_r[s_prev];
  assign t_end    = (t_r >= ut);
  assign cur_max  = cm_r[s_r];
  assign cap_bit  = cap_r[s_r][t_idx];
  assign nl       = load_r[t_idx] + CNT_W'(1);
  assign nm       = (nl > cur_max) ? nl : cur_max;
  assign conf_row = conf_r[s_r];
  assign prune    = (best_r <= lb_r);
  assign leaf     = ((CNT_W'(s_r) + CNT_W'(1)) >= us);

  // Clash against earlier subjects on the current path
  always_comb begin
    for (int i = 0; i < MAX_SUBJECTS; i++) begin
      hit[i] = conf_row[i] && (SW'(i) < s_r) && (assigned_r[i] == t_idx);
    end
  end
  assign clash = |hit;
  assign ok    = cap_bit && (nm < best_r) && !clash;

  // Status
  assign status.div_last    = (rem_r <= ut);
  assign status.search_done = !pending_r && ((t_end && (s_r == '0)) || (!t_end && prune));
  assign status.out_free    = !out_valid_r || !out_stall;

  // Configuration registers (set to 1) and tables (cleared) at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tc_r <= CNT_W'(1);
      sc_r <= CNT_W'(1);
      for (int i = 0; i < MAX_SUBJECTS; i++) begin
        cap_r[i]  <= '0;
        conf_r[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_TEACHER_COUNT: tc_r <= cfg_data;
          CFG_SUBJECT_COUNT: sc_r <= cfg_data;
          default:           ;
        endcase
      end
      if (cmd.load_cap && cap_ok) begin
        cap_r[in_second_index[SW-1:0]][in_first_index[TW-1:0]] <= 1'b1;
      end
      if (cmd.load_conf && conf_ok) begin
        conf_r[in_first_index[SW-1:0]][in_second_index[SW-1:0]] <= 1'b1;
        conf_r[in_second_index[SW-1:0]][in_first_index[SW-1:0]] <= 1'b1;
      end
    end
  end

  // Search control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r       <= '0;
      t_r       <= '0;
      pending_r <= 1'b0;
      best_r    <= NONE_YET;
      lb_r      <= '0;
      rem_r     <= '0;
    end else if (cmd.start) begin
      s_r       <= '0;
      t_r       <= '0;
      pending_r <= 1'b0;
      best_r    <= NONE_YET;
      lb_r      <= '0;
      rem_r     <= us;
    end else if (cmd.div_step) begin
      // ceiling of subjects over teachers by repeated subtraction
      lb_r  <= lb_r + CNT_W'(1);
      rem_r <= (rem_r > ut) ? (rem_r - ut) : '0;
    end else if (cmd.search_step && !status.search_done) begin
      if (pending_r) begin
        pending_r <= 1'b0;
        t_r       <= t_r + CNT_W'(1);
      end else if (t_end) begin
        // level exhausted: step back to the previous subject
        s_r       <= s_prev;
        t_r       <= CNT_W'(tp);
        pending_r <= 1'b1;
      end else if (ok && leaf) begin
        best_r <= nm;
        t_r    <= t_r + CNT_W'(1);
      end else if (ok) begin
        s_r <= s_next;
        t_r <= '0;
      end else begin
        t_r <= t_r + CNT_W'(1);
      end
    end
  end

  // Loads, path and per-level maximum
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      for (int i = 0; i < MAX_TEACHERS; i++) load_r[i] <= '0;
      cm_r[0] <= '0;
    end else if (cmd.search_step && !status.search_done) begin
      if (pending_r) begin
        load_r[t_idx] <= load_r[t_idx] - CNT_W'(1);
      end else if (!t_end && ok && !leaf) begin
        assigned_r[s_r] <= t_idx;
        load_r[t_idx]   <= nl;
        cm_r[s_next]    <= nm;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_found_r     <= (best_r != NONE_YET);
      out_best_load_r <= (best_r != NONE_YET) ? best_r : '0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_best_load = out_best_load_r;
  assign out_found     = out_found_r;

endmodule

FILE: design/bls_checker.sv
// Port-level checker for the assignment search, bound to the top level.
module bls_checker
  import bls_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic [ACT_W-1:0]  in_action,
  input logic              out_valid,
  input logic              out_stall,
  input logic [CNT_W-1:0]  out_best_load,
  input logic              out_found
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_best_load) && $stable(out_found))
    else $error("result word changed while stalled");

  // No assignment reports a zero load
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_best_load == '0)
    else $error("load nonzero without assignment");

  // A found assignment has a load between 1 and 32
  a_found_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> (out_best_load != '0) && (out_best_load <= CNT_W'(32)))
    else $error("found load out of range");

  // A solve word blocks intake on the next cycle
  a_solve_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_action == ACT_SOLVE) |=> in_stall)
    else $error("intake open right after solve");

  // A new result appears only at the end of a search
  a_result_after_search: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a search");

endmodule

bind balanced_list_assignment_search bls_checker u_bls_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_action     (in_action),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_best_load (out_best_load),
  .out_found     (out_found)
);
